>>> rtl/gts_pkg.sv
package gts_pkg;

  localparam int unsigned MAX_FRAMES_DEF = 4096;
  localparam int unsigned MAX_RADIUS_DEF = 32;

  localparam int unsigned MOT_W     = 32;
  localparam int unsigned VAL_W     = 48;
  localparam int unsigned WT_W      = 17;
  localparam int unsigned FIDX_W    = 12;
  localparam int unsigned WIDX_W    = 6;
  localparam int unsigned CNT_OUT_W = 13;
  localparam int unsigned RAD_W     = 6;
  localparam int unsigned LIM_W     = 31;
  localparam int unsigned CFG_W     = 31;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [RAD_W-1:0] RADIUS_RST = RAD_W'(8);
  localparam logic [LIM_W-1:0] TRANS_RST  = LIM_W'(32768);
  localparam logic [LIM_W-1:0] ROT_RST    = LIM_W'(268435);

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_SMOOTH = 2'd1,
    OP_WEIGHT = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STS_OK       = 2'd0,
    STS_FULL     = 2'd1,
    STS_UNSTORED = 2'd2,
    STS_DONE     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CFG_RADIUS = 2'd0,
    CFG_TRANS  = 2'd1,
    CFG_ROT    = 2'd2
  } cfg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_CHECK,
    S_WALK,
    S_DRAIN,
    S_DIV,
    S_FINISH,
    S_RESP
  } state_e;

  typedef struct packed {
    logic latch;
    logic exec;
    logic chk;
    logic step;
    logic div_start;
    logic div_step;
    logic finish;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic smooth_err;
    logic walk_last;
    logic pipe_busy;
    logic div_last;
  } sts_t;

  function automatic logic [MOT_W:0] mag33(input logic signed [MOT_W-1:0] m);
    logic signed [MOT_W:0] x;
    x = (MOT_W+1)'(m);
    return x[MOT_W] ? (MOT_W+1)'(-x) : (MOT_W+1)'(x);
  endfunction

endpackage

>>> rtl/gts_ram.sv
module gts_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/gts_ctrl.sv
module gts_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  gts_pkg::sts_t sts_i,
  output gts_pkg::cmd_t cmd_o
);

  gts_pkg::state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      gts_pkg::S_IDLE:   if (in_valid_i) state_d = gts_pkg::S_EXEC;
      gts_pkg::S_EXEC: begin
        state_d = (sts_i.op == gts_pkg::OP_SMOOTH) ? gts_pkg::S_CHECK : gts_pkg::S_RESP;
      end
      gts_pkg::S_CHECK:  state_d = sts_i.smooth_err ? gts_pkg::S_RESP : gts_pkg::S_WALK;
      gts_pkg::S_WALK:   if (sts_i.walk_last) state_d = gts_pkg::S_DRAIN;
      gts_pkg::S_DRAIN:  if (!sts_i.pipe_busy) state_d = gts_pkg::S_DIV;
      gts_pkg::S_DIV:    if (sts_i.div_last) state_d = gts_pkg::S_FINISH;
      gts_pkg::S_FINISH: state_d = gts_pkg::S_RESP;
      gts_pkg::S_RESP:   if (slot_free) state_d = gts_pkg::S_IDLE;
      default:           state_d = gts_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_ready_o = 1'b0;
    case (state_q)
      gts_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.latch = in_valid_i;
      end
      gts_pkg::S_EXEC:   cmd_o.exec = 1'b1;
      gts_pkg::S_CHECK:  cmd_o.chk = 1'b1;
      gts_pkg::S_WALK:   cmd_o.step = 1'b1;
      gts_pkg::S_DRAIN:  cmd_o.div_start = !sts_i.pipe_busy;
      gts_pkg::S_DIV:    cmd_o.div_step = 1'b1;
      gts_pkg::S_FINISH: cmd_o.finish = 1'b1;
      gts_pkg::S_RESP:   cmd_o.load_out = slot_free;
      default:           cmd_o = '0;
    endcase
  end

  assign out_valid_d = cmd_o.load_out || (out_valid_q && !out_ready_i);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gts_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

>>> rtl/gts_datapath.sv
module gts_datapath #(
  parameter int unsigned MAX_FRAMES = gts_pkg::MAX_FRAMES_DEF,
  parameter int unsigned MAX_RADIUS = gts_pkg::MAX_RADIUS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  gts_pkg::cmd_t                        cmd_i,
  output gts_pkg::sts_t                        sts_o,
  input  logic                                 cfg_valid_i,
  input  logic [gts_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [gts_pkg::CFG_W-1:0]            cfg_data_i,
  input  logic [1:0]                           operation_i,
  input  logic signed [gts_pkg::MOT_W-1:0]     motion_u_i,
  input  logic signed [gts_pkg::MOT_W-1:0]     motion_v_i,
  input  logic signed [gts_pkg::MOT_W-1:0]     motion_a_i,
  input  logic [gts_pkg::FIDX_W-1:0]           frame_index_i,
  input  logic [gts_pkg::WIDX_W-1:0]           weight_index_i,
  input  logic [gts_pkg::WT_W-1:0]             weight_value_i,
  output logic signed [gts_pkg::VAL_W-1:0]     smoothed_u_o,
  output logic signed [gts_pkg::VAL_W-1:0]     smoothed_v_o,
  output logic signed [gts_pkg::VAL_W-1:0]     smoothed_a_o,
  output logic                                 is_still_o,
  output logic [gts_pkg::CNT_OUT_W-1:0]        frames_stored_o,
  output logic [1:0]                           status_o
);

  localparam int unsigned VW     = gts_pkg::VAL_W;
  localparam int unsigned AW     = $clog2(MAX_FRAMES);
  localparam int unsigned CNT_W  = $clog2(MAX_FRAMES + 1);
  localparam int unsigned RW     = (MAX_RADIUS > 0) ? $clog2(MAX_RADIUS + 1) : 1;
  localparam int unsigned KW     = $clog2(2 * MAX_RADIUS + 1);
  localparam int unsigned PROD_W = VW + gts_pkg::WT_W;
  localparam int unsigned ACC_W  = PROD_W + KW + 1;
  localparam int unsigned WS_W   = gts_pkg::WT_W + KW;
  localparam int unsigned NUM_W  = ACC_W;
  localparam int unsigned DCW    = $clog2(NUM_W + 1);

  logic [gts_pkg::RAD_W-1:0] radius_q;
  logic [gts_pkg::LIM_W-1:0] trans_lim_q, rot_lim_q;

  gts_pkg::op_e                   op_q;
  logic signed [gts_pkg::MOT_W-1:0] mot_q [3];
  logic [gts_pkg::FIDX_W-1:0]     fidx_q;
  logic [gts_pkg::WIDX_W-1:0]     widx_q;
  logic [gts_pkg::WT_W-1:0]       wval_q;

  logic [CNT_W-1:0]      count_q;
  logic signed [VW-1:0]  rs_q [3];
  logic signed [VW-1:0]  prev_q [3];
  logic [MAX_RADIUS:0]   wv_q;

  logic [RW-1:0]         r_q;
  logic [KW-1:0]         k_q;
  logic                  still_q;
  logic                  s1_v_q, s1_ctr_q, s1_wv_q;
  logic                  s2_v_q;
  logic [PROD_W-1:0]     prod_q [3];
  logic                  psgn_q [3];
  logic [ACC_W-1:0]      acc_q [3];
  logic [WS_W-1:0]       wsum_q;
  logic signed [VW-1:0]  ctr_q [3];
  logic                  neg_q [3];
  logic [WS_W-1:0]       rem_q [3];
  logic [NUM_W-1:0]      qn_q [3];
  logic [DCW-1:0]        dcnt_q;

  logic signed [VW-1:0]  res_q [3];
  logic                  res_still_q;
  gts_pkg::status_e      res_sts_q;

  logic [3*VW-1:0]       sum_wdata, sum_rdata;
  logic [1:0]            flg_wdata, flg_rdata;
  logic [AW-1:0]         flg_waddr, walk_addr, fidx_addr, cnt_addr;
  logic                  sum_we, flg_we, wt_we;
  logic [gts_pkg::WT_W-1:0] wt_rdata;
  logic [RW-1:0]         wt_raddr;

  logic signed [VW-1:0]  rs_n [3];
  logic                  full, app_still, unstored, smooth_err;
  logic [RW-1:0]         r_eff;
  int                    offs, adist, idx;
  logic signed [VW-1:0]  avg [3];
  logic signed [VW+1:0]  dsum [3];
  logic signed [VW+1:0]  dhalf [3];
  logic signed [VW-1:0]  dnew [3];

  assign cnt_addr  = AW'(count_q);
  assign fidx_addr = AW'(fidx_q);
  assign full      = (32'(count_q) == MAX_FRAMES);
  assign unstored  = (32'(fidx_q) >= 32'(count_q));
  assign smooth_err = unstored || flg_rdata[1];
  assign r_eff = (32'(radius_q) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(radius_q);

  assign app_still = (count_q != '0)
                  && (gts_pkg::mag33(mot_q[0]) < {2'b00, trans_lim_q})
                  && (gts_pkg::mag33(mot_q[1]) < {2'b00, trans_lim_q})
                  && (gts_pkg::mag33(mot_q[2]) < {2'b00, rot_lim_q});

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      rs_n[c] = rs_q[c] + VW'(mot_q[c]);
    end
  end

  always_comb begin
    offs  = int'(k_q) - int'(r_q);
    adist = (offs < 0) ? -offs : offs;
    idx   = int'(fidx_q) + offs;
    if (idx < 0) idx = 0;
    if (idx > int'(count_q) - 1) idx = int'(count_q) - 1;
    walk_addr = AW'(idx);
    wt_raddr  = RW'(adist);
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (wsum_q == '0) begin
        avg[c] = '0;
      end else if (neg_q[c]) begin
        avg[c] = VW'(-qn_q[c][VW-1:0]);
      end else begin
        avg[c] = qn_q[c][VW-1:0];
      end
      dsum[c] = (VW+2)'(ctr_q[c]) - (VW+2)'(avg[c]);
      if (still_q) begin
        dsum[c] = dsum[c] + (VW+2)'(prev_q[c]);
      end
      dhalf[c] = (dsum[c] + (VW+2)'({1'b0, dsum[c][VW+1]})) >>> 1;
      dnew[c]  = still_q ? dhalf[c][VW-1:0] : dsum[c][VW-1:0];
    end
  end

  assign sum_we    = cmd_i.exec && (op_q == gts_pkg::OP_APPEND) && !full;
  assign sum_wdata = {rs_n[2], rs_n[1], rs_n[0]};
  assign flg_we    = sum_we || cmd_i.finish;
  assign flg_waddr = cmd_i.finish ? fidx_addr : cnt_addr;
  assign flg_wdata = cmd_i.finish ? {1'b1, still_q} : {1'b0, app_still};
  assign wt_we     = cmd_i.exec && (op_q == gts_pkg::OP_WEIGHT)
                  && (32'(widx_q) <= MAX_RADIUS);

  gts_ram #(.WIDTH(3 * VW), .DEPTH(MAX_FRAMES)) u_sum_ram (
    .clk_i   (clk_i),
    .we_i    (sum_we),
    .waddr_i (cnt_addr),
    .wdata_i (sum_wdata),
    .raddr_i (walk_addr),
    .rdata_o (sum_rdata)
  );

  gts_ram #(.WIDTH(2), .DEPTH(MAX_FRAMES)) u_flag_ram (
    .clk_i   (clk_i),
    .we_i    (flg_we),
    .waddr_i (flg_waddr),
    .wdata_i (flg_wdata),
    .raddr_i (fidx_addr),
    .rdata_o (flg_rdata)
  );

  gts_ram #(.WIDTH(gts_pkg::WT_W), .DEPTH(MAX_RADIUS + 1)) u_wt_ram (
    .clk_i   (clk_i),
    .we_i    (wt_we),
    .waddr_i (RW'(widx_q)),
    .wdata_i (wval_q),
    .raddr_i (wt_raddr),
    .rdata_o (wt_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q    <= gts_pkg::RADIUS_RST;
      trans_lim_q <= gts_pkg::TRANS_RST;
      rot_lim_q   <= gts_pkg::ROT_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        gts_pkg::CFG_RADIUS: radius_q    <= cfg_data_i[gts_pkg::RAD_W-1:0];
        gts_pkg::CFG_TRANS:  trans_lim_q <= cfg_data_i[gts_pkg::LIM_W-1:0];
        gts_pkg::CFG_ROT:    rot_lim_q   <= cfg_data_i[gts_pkg::LIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q     <= gts_pkg::op_e'(operation_i);
      mot_q[0] <= motion_u_i;
      mot_q[1] <= motion_v_i;
      mot_q[2] <= motion_a_i;
      fidx_q   <= frame_index_i;
      widx_q   <= weight_index_i;
      wval_q   <= weight_value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      wv_q    <= '0;
      for (int c = 0; c < 3; c++) begin
        rs_q[c]   <= '0;
        prev_q[c] <= '0;
      end
    end else begin
      if (sum_we) begin
        count_q <= count_q + CNT_W'(1);
        for (int c = 0; c < 3; c++) rs_q[c] <= rs_n[c];
      end
      if (cmd_i.exec && (op_q == gts_pkg::OP_CLEAR)) begin
        for (int c = 0; c < 3; c++) rs_q[c] <= '0;
      end
      if (wt_we) begin
        wv_q[RW'(widx_q)] <= 1'b1;
      end
      if (cmd_i.finish) begin
        for (int c = 0; c < 3; c++) prev_q[c] <= dnew[c];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= cmd_i.step;
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.chk) begin
      r_q     <= r_eff;
      k_q     <= '0;
      still_q <= flg_rdata[0];
      wsum_q  <= '0;
      for (int c = 0; c < 3; c++) acc_q[c] <= '0;
    end
    if (cmd_i.step) begin
      k_q      <= k_q + KW'(1);
      s1_ctr_q <= (offs == 0);
      s1_wv_q  <= wv_q[wt_raddr];
    end
    if (s1_v_q) begin
      wsum_q <= wsum_q + WS_W'(s1_wv_q ? wt_rdata : '0);
      for (int c = 0; c < 3; c++) begin
        logic [VW-1:0] sv, mg;
        sv = sum_rdata[c*VW +: VW];
        mg = sv[VW-1] ? VW'(-sv) : sv;
        psgn_q[c] <= sv[VW-1];
        prod_q[c] <= PROD_W'(mg) * PROD_W'(s1_wv_q ? wt_rdata : '0);
        if (s1_ctr_q) ctr_q[c] <= sv;
      end
    end
    if (s2_v_q) begin
      for (int c = 0; c < 3; c++) begin
        acc_q[c] <= psgn_q[c] ? acc_q[c] - ACC_W'(prod_q[c])
                              : acc_q[c] + ACC_W'(prod_q[c]);
      end
    end
    if (cmd_i.div_start) begin
      dcnt_q <= DCW'(NUM_W);
      for (int c = 0; c < 3; c++) begin
        logic [ACC_W-1:0] am;
        am = acc_q[c][ACC_W-1] ? ACC_W'(-acc_q[c]) : acc_q[c];
        neg_q[c] <= acc_q[c][ACC_W-1];
        rem_q[c] <= '0;
        qn_q[c]  <= am + NUM_W'(wsum_q >> 1);
      end
    end
    if (cmd_i.div_step) begin
      dcnt_q <= dcnt_q - DCW'(1);
      for (int c = 0; c < 3; c++) begin
        logic [WS_W:0] t;
        t = {rem_q[c], qn_q[c][NUM_W-1]};
        if (t >= {1'b0, wsum_q}) begin
          rem_q[c] <= WS_W'(t - {1'b0, wsum_q});
          qn_q[c]  <= {qn_q[c][NUM_W-2:0], 1'b1};
        end else begin
          rem_q[c] <= t[WS_W-1:0];
          qn_q[c]  <= {qn_q[c][NUM_W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && (op_q != gts_pkg::OP_SMOOTH)) begin
      for (int c = 0; c < 3; c++) res_q[c] <= '0;
      res_still_q <= (op_q == gts_pkg::OP_APPEND) && !full && app_still;
      res_sts_q   <= ((op_q == gts_pkg::OP_APPEND) && full) ? gts_pkg::STS_FULL
                                                            : gts_pkg::STS_OK;
    end
    if (cmd_i.chk && smooth_err) begin
      for (int c = 0; c < 3; c++) res_q[c] <= '0;
      res_still_q <= 1'b0;
      res_sts_q   <= unstored ? gts_pkg::STS_UNSTORED : gts_pkg::STS_DONE;
    end
    if (cmd_i.finish) begin
      for (int c = 0; c < 3; c++) res_q[c] <= dnew[c];
      res_still_q <= still_q;
      res_sts_q   <= gts_pkg::STS_OK;
    end
    if (cmd_i.load_out) begin
      smoothed_u_o    <= res_q[0];
      smoothed_v_o    <= res_q[1];
      smoothed_a_o    <= res_q[2];
      is_still_o      <= res_still_q;
      frames_stored_o <= gts_pkg::CNT_OUT_W'(count_q);
      status_o        <= res_sts_q;
    end
  end

  assign sts_o.op         = op_q;
  assign sts_o.smooth_err = smooth_err;
  assign sts_o.walk_last  = (int'(k_q) == 2 * int'(r_q));
  assign sts_o.pipe_busy  = s1_v_q || s2_v_q;
  assign sts_o.div_last   = (dcnt_q == DCW'(1));

endmodule

>>> rtl/gaussian_trajectory_smoother.sv
// One request at a time. Append, weight load and running-sum clear pass
// through the execute and response states; a smooth request with error status
// passes through execute, check and response. A successful smooth walks the
// 2r+1 window entries (r being the clamped window radius) one per cycle through
// the frame store's single read port, drains a two-stage multiply-accumulate,
// then runs a bit-serial divider of the ACC_W-bit accumulator (73 bits at
// the default radius limit) by the weight sum. The next request is taken
// while the previous result still waits on the output. The frame store needs
// no clearing pass: only frames below the fill count are ever read.
module gaussian_trajectory_smoother #(
  parameter int unsigned MAX_FRAMES = gts_pkg::MAX_FRAMES_DEF,
  parameter int unsigned MAX_RADIUS = gts_pkg::MAX_RADIUS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [gts_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [gts_pkg::CFG_W-1:0]        cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [1:0]                       operation_i,
  input  logic signed [gts_pkg::MOT_W-1:0] motion_u_i,
  input  logic signed [gts_pkg::MOT_W-1:0] motion_v_i,
  input  logic signed [gts_pkg::MOT_W-1:0] motion_a_i,
  input  logic [gts_pkg::FIDX_W-1:0]       frame_index_i,
  input  logic [gts_pkg::WIDX_W-1:0]       weight_index_i,
  input  logic [gts_pkg::WT_W-1:0]         weight_value_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [gts_pkg::VAL_W-1:0] smoothed_u_o,
  output logic signed [gts_pkg::VAL_W-1:0] smoothed_v_o,
  output logic signed [gts_pkg::VAL_W-1:0] smoothed_a_o,
  output logic                             is_still_o,
  output logic [gts_pkg::CNT_OUT_W-1:0]    frames_stored_o,
  output logic [1:0]                       status_o
);

  gts_pkg::cmd_t cmd;
  gts_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  gts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  gts_datapath #(.MAX_FRAMES(MAX_FRAMES), .MAX_RADIUS(MAX_RADIUS)) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .operation_i     (operation_i),
    .motion_u_i      (motion_u_i),
    .motion_v_i      (motion_v_i),
    .motion_a_i      (motion_a_i),
    .frame_index_i   (frame_index_i),
    .weight_index_i  (weight_index_i),
    .weight_value_i  (weight_value_i),
    .smoothed_u_o    (smoothed_u_o),
    .smoothed_v_o    (smoothed_v_o),
    .smoothed_a_o    (smoothed_a_o),
    .is_still_o      (is_still_o),
    .frames_stored_o (frames_stored_o),
    .status_o        (status_o)
  );

endmodule

>>> rtl/gts_checker.sv
module gts_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_o,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input logic signed [gts_pkg::VAL_W-1:0] smoothed_u_o,
  input logic signed [gts_pkg::VAL_W-1:0] smoothed_v_o,
  input logic signed [gts_pkg::VAL_W-1:0] smoothed_a_o,
  input logic                             is_still_o,
  input logic [1:0]                       status_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(status_o) && $stable(smoothed_u_o))
    else $error("stalled result changed");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != gts_pkg::STS_OK) |->
      (smoothed_u_o == '0) && (smoothed_v_o == '0) && (smoothed_a_o == '0) && !is_still_o)
    else $error("error result carries data");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while busy");

endmodule

bind gaussian_trajectory_smoother gts_checker u_gts_checker (.*);

>>> tb/smoother_checker.sv
module smoother_checker
  import gts_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  input  logic                      cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [CFG_W-1:0]          cfg_data_i,
  input  logic                      in_valid_i,
  input  logic                      in_ready_i,
  input  logic [1:0]                operation_i,
  input  logic signed [MOT_W-1:0]   motion_u_i,
  input  logic signed [MOT_W-1:0]   motion_v_i,
  input  logic signed [MOT_W-1:0]   motion_a_i,
  input  logic [FIDX_W-1:0]         frame_index_i,
  input  logic [WIDX_W-1:0]         weight_index_i,
  input  logic [WT_W-1:0]           weight_value_i,
  input  logic                      out_valid_i,
  input  logic                      out_ready_i,
  input  logic signed [VAL_W-1:0]   smoothed_u_i,
  input  logic signed [VAL_W-1:0]   smoothed_v_i,
  input  logic signed [VAL_W-1:0]   smoothed_a_i,
  input  logic                      is_still_i,
  input  logic [CNT_OUT_W-1:0]      frames_stored_i,
  input  logic [1:0]                status_i,
  output int                        fail_count,
  output int                        pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NFRAMES = MAX_FRAMES_DEF;
  localparam int NRADIUS = MAX_RADIUS_DEF;

  typedef struct {
    logic signed [VAL_W-1:0] corr [3];
    logic                    still;
    logic [CNT_OUT_W-1:0]    stored;
    logic [1:0]              sts;
  } correction_t;

  correction_t             expected_corrections[$];

  logic [RAD_W-1:0]        radius;
  logic [LIM_W-1:0]        trans_limit;
  logic [LIM_W-1:0]        rot_limit;
  logic signed [VAL_W-1:0] path_sum [3];
  logic signed [VAL_W-1:0] path_store [NFRAMES][3];
  logic signed [VAL_W-1:0] smooth_store [NFRAMES][3];
  logic                    still_flag [NFRAMES];
  logic                    done_flag [NFRAMES];
  logic signed [VAL_W-1:0] last_delta [3];
  logic [WT_W-1:0]         weights [NRADIUS+1];
  int                      stored_frames;

  function automatic logic [MOT_W:0] magnitude(input logic signed [MOT_W-1:0] x);
    logic signed [MOT_W:0] w;
    w = (MOT_W+1)'(x);
    return (w < 0) ? -w : w;
  endfunction

  function automatic logic signed [VAL_W-1:0] window_mean(input int f, input int c,
                                                          input int r);
    logic signed [127:0] acc;
    logic signed [127:0] term;
    logic [127:0]        absval;
    logic [127:0]        quo;
    logic [31:0]         wsum;
    logic [VAL_W-1:0]    res;
    int                  idx;
    acc = 0;
    wsum = 0;
    for (int d = -r; d <= r; d++) begin
      idx = f + d;
      if (idx < 0) idx = 0;
      if (idx > stored_frames - 1) idx = stored_frames - 1;
      term = 128'(path_store[idx][c]);
      acc = acc + term * $signed({111'b0, weights[d < 0 ? -d : d]});
      wsum = wsum + 32'(weights[d < 0 ? -d : d]);
    end
    if (wsum == 0) return '0;
    absval = (acc < 0) ? -acc : acc;
    quo = (absval + 128'(wsum >> 1)) / 128'(wsum);
    res = quo[VAL_W-1:0];
    return (acc < 0) ? -res : res;
  endfunction

  task automatic predict_request();
    correction_t             exp;
    logic signed [MOT_W-1:0] mot [3];
    logic signed [VAL_W-1:0] mean;
    logic signed [63:0]      delta;
    logic signed [63:0]      prev;
    int                      f;
    int                      r;
    exp.corr = '{default: '0};
    exp.still = 1'b0;
    exp.sts = STS_OK;
    mot = '{motion_u_i, motion_v_i, motion_a_i};
    case (op_e'(operation_i))
      OP_APPEND: begin
        if (stored_frames >= NFRAMES) begin
          exp.sts = STS_FULL;
        end else begin
          for (int c = 0; c < 3; c++) begin
            path_sum[c] = path_sum[c] + VAL_W'(mot[c]);
            path_store[stored_frames][c] = path_sum[c];
            smooth_store[stored_frames][c] = '0;
          end
          exp.still = stored_frames > 0 && magnitude(mot[0]) < trans_limit &&
                      magnitude(mot[1]) < trans_limit && magnitude(mot[2]) < rot_limit;
          still_flag[stored_frames] = exp.still;
          done_flag[stored_frames] = 1'b0;
          stored_frames++;
        end
      end
      OP_SMOOTH: begin
        f = int'(frame_index_i);
        if (f >= stored_frames) begin
          exp.sts = STS_UNSTORED;
        end else if (done_flag[f]) begin
          exp.sts = STS_DONE;
        end else begin
          r = (int'(radius) > NRADIUS) ? NRADIUS : int'(radius);
          exp.still = still_flag[f];
          for (int c = 0; c < 3; c++) begin
            mean = window_mean(f, c, r);
            delta = 64'(path_store[f][c]);
            delta = delta - 64'(mean);
            if (exp.still) begin
              prev = 64'(last_delta[c]);
              delta = (prev + delta) / 2;
            end
            last_delta[c] = delta[VAL_W-1:0];
            smooth_store[f][c] = smooth_store[f][c] + delta[VAL_W-1:0];
            exp.corr[c] = smooth_store[f][c];
          end
          done_flag[f] = 1'b1;
        end
      end
      OP_WEIGHT: begin
        if (weight_index_i <= NRADIUS) weights[weight_index_i] = weight_value_i;
      end
      default: begin
        path_sum = '{default: '0};
      end
    endcase
    exp.stored = CNT_OUT_W'(stored_frames);
    expected_corrections = {expected_corrections, exp};
  endtask

  function automatic void check_field(input string name, input logic [VAL_W-1:0] exp,
                                      input logic [VAL_W-1:0] act);
    if (exp !== act) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp, act);
      fail_count++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    correction_t exp;
    if (!rst_ni) begin
      radius = RADIUS_RST;
      trans_limit = TRANS_RST;
      rot_limit = ROT_RST;
      path_sum = '{default: '0};
      last_delta = '{default: '0};
      weights = '{default: '0};
      for (int i = 0; i < NFRAMES; i++) begin
        still_flag[i] = 1'b0;
        done_flag[i] = 1'b0;
      end
      stored_frames = 0;
      expected_corrections.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_e'(cfg_index_i))
          CFG_RADIUS: radius = cfg_data_i[RAD_W-1:0];
          CFG_TRANS:  trans_limit = cfg_data_i;
          CFG_ROT:    rot_limit = cfg_data_i;
          default:    ;
        endcase
      end
      if (in_valid_i && in_ready_i) predict_request();
      if (out_valid_i && out_ready_i) begin
        if (expected_corrections.size() == 0) begin
          $display("%0t: unexpected result, expected none actual status %0d",
                   $time, status_i);
          fail_count++;
        end else begin
          exp = expected_corrections.pop_front();
          check_field("smoothed_u", exp.corr[0], smoothed_u_i);
          check_field("smoothed_v", exp.corr[1], smoothed_v_i);
          check_field("smoothed_a", exp.corr[2], smoothed_a_i);
          check_field("is_still", VAL_W'(exp.still), VAL_W'(is_still_i));
          check_field("frames_stored", VAL_W'(exp.stored), VAL_W'(frames_stored_i));
          check_field("status", VAL_W'(exp.sts), VAL_W'(status_i));
        end
      end
    end
    pending = expected_corrections.size();
  end

endmodule

>>> tb/gaussian_trajectory_smoother_test.sv
module gaussian_trajectory_smoother_test;
  import gts_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int                   DRAIN_CYCLES = 250;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic [CFG_IDX_W-1:0]    cfg_index_i;
  logic [CFG_W-1:0]        cfg_data_i;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic [1:0]              operation_i;
  logic signed [MOT_W-1:0] motion_u_i;
  logic signed [MOT_W-1:0] motion_v_i;
  logic signed [MOT_W-1:0] motion_a_i;
  logic [FIDX_W-1:0]       frame_index_i;
  logic [WIDX_W-1:0]       weight_index_i;
  logic [WT_W-1:0]         weight_value_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic signed [VAL_W-1:0] smoothed_u_o;
  logic signed [VAL_W-1:0] smoothed_v_o;
  logic signed [VAL_W-1:0] smoothed_a_o;
  logic                    is_still_o;
  logic [CNT_OUT_W-1:0]    frames_stored_o;
  logic [1:0]              status_o;
  int                      fail_count;
  int                      pending;
  int                      appended;
  int                      request_num;

  gaussian_trajectory_smoother DUT (.*);

  smoother_checker u_checker (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .operation_i, .motion_u_i, .motion_v_i,
    .motion_a_i, .frame_index_i, .weight_index_i, .weight_value_i,
    .out_valid_i(out_valid_o), .out_ready_i, .smoothed_u_i(smoothed_u_o),
    .smoothed_v_i(smoothed_v_o), .smoothed_a_i(smoothed_a_o), .is_still_i(is_still_o),
    .frames_stored_i(frames_stored_o), .status_i(status_o), .fail_count, .pending
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  function automatic int idle_gap(input int n);
    return ((n / 120) % 4 == 3) ? 0 : $urandom_range(0, 10);
  endfunction

  task automatic send_request(input op_e op, input logic [31:0] u, input logic [31:0] v,
                              input logic [31:0] a, input logic [31:0] fi,
                              input logic [31:0] wi, input logic [31:0] wv);
    int gap;
    in_valid_i <= 1'b1;
    operation_i <= op;
    motion_u_i <= u;
    motion_v_i <= v;
    motion_a_i <= a;
    frame_index_i <= fi[FIDX_W-1:0];
    weight_index_i <= wi[WIDX_W-1:0];
    weight_value_i <= wv[WT_W-1:0];
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (op == OP_APPEND && appended < 4096) appended++;
    request_num++;
    gap = idle_gap(request_num);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val[CFG_W-1:0];
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_motion(input int still_range);
    case ($urandom_range(0, 5))
      0:       return $urandom();
      1:       return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
      2:       return 32'($signed($urandom_range(0, 2 * still_range)) - still_range);
      default: return 32'($signed($urandom_range(0, 2 * 3 * still_range)) - 3 * still_range);
    endcase
  endfunction

  function automatic logic [31:0] pick_frame();
    int lo;
    if (appended == 0 || $urandom_range(0, 9) == 0) return $urandom();
    lo = (appended > 40) ? appended - 40 : 0;
    if ($urandom_range(0, 2) == 0) return $urandom_range(0, appended - 1);
    return $urandom_range(lo, appended - 1);
  endfunction

  task automatic random_request(input int append_pct);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < append_pct) begin
      send_request(OP_APPEND, pick_motion(40000), pick_motion(40000), pick_motion(300000),
                   $urandom(), $urandom(), $urandom());
    end else if (pick < 85) begin
      send_request(OP_SMOOTH, $urandom(), $urandom(), $urandom(), pick_frame(),
                   $urandom(), $urandom());
    end else if (pick < 96) begin
      send_request(OP_WEIGHT, $urandom(), $urandom(), $urandom(), $urandom(),
                   $urandom_range(0, 5) == 0 ? $urandom_range(0, 63) : $urandom_range(0, 32),
                   $urandom_range(0, 3) == 0 ? $urandom_range(0, 131071)
                                             : $urandom_range(0, 65536));
    end else begin
      send_request(OP_CLEAR, $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                   $urandom());
    end
  endtask

  initial begin
    int n;
    int hold;
    out_ready_i <= 1'b0;
    n = 0;
    @(posedge rst_ni);
    forever begin
      hold = (n == 500) ? 3000 : idle_gap(n);
      if (hold > 0) begin
        out_ready_i <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      n++;
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    operation_i = OP_APPEND;
    motion_u_i = '0;
    motion_v_i = '0;
    motion_a_i = '0;
    frame_index_i = '0;
    weight_index_i = '0;
    weight_value_i = '0;
    appended = 0;
    request_num = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_request(OP_SMOOTH, 0, 0, 0, 0, 0, 0);
    send_request(OP_APPEND, 32'h0000_1000, 32'hffff_f000, 32'h0000_0100, 0, 0, 0);
    send_request(OP_APPEND, 32'h0000_7fff, 32'hffff_8001, 32'h0004_1892, 0, 0, 0);
    send_request(OP_APPEND, 32'h0000_8000, 0, 0, 0, 0, 0);
    send_request(OP_SMOOTH, 0, 0, 0, 1, 0, 0);
    send_request(OP_WEIGHT, 0, 0, 0, 0, 0, 65536);
    send_request(OP_WEIGHT, 0, 0, 0, 0, 1, 40000);
    send_request(OP_WEIGHT, 0, 0, 0, 0, 2, 9000);
    send_request(OP_WEIGHT, 0, 0, 0, 0, 32, 32'h1ffff);
    send_request(OP_WEIGHT, 0, 0, 0, 0, 33, 5);
    send_request(OP_WEIGHT, 0, 0, 0, 0, 63, 7);
    send_request(OP_APPEND, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 0, 0, 0);
    send_request(OP_APPEND, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 0, 0, 0);
    send_request(OP_APPEND, 32'hffff_ffff, 32'h0000_0001, 32'hffff_ffff, 0, 0, 0);
    send_request(OP_SMOOTH, 0, 0, 0, 0, 0, 0);
    send_request(OP_SMOOTH, 0, 0, 0, 2, 0, 0);
    send_request(OP_SMOOTH, 0, 0, 0, 2, 0, 0);
    send_request(OP_SMOOTH, 0, 0, 0, 6, 0, 0);
    send_request(OP_SMOOTH, 0, 0, 0, 32'hfff, 0, 0);
    send_request(OP_CLEAR, 0, 0, 0, 0, 0, 0);
    send_request(OP_APPEND, 32'h0000_0010, 0, 0, 0, 0, 0);
    send_request(OP_SMOOTH, 0, 0, 0, 7, 0, 0);

    for (int p = 0; p < 6; p++) begin
      drain();
      case (p)
        0: begin
          write_reg(CFG_RADIUS, 0);
          write_reg(CFG_TRANS, 32'h7fff_ffff);
          write_reg(CFG_ROT, 32'h7fff_ffff);
          write_reg(CFG_SPARE, $urandom());
        end
        1: begin
          write_reg(CFG_RADIUS, 32);
          write_reg(CFG_TRANS, 0);
          write_reg(CFG_ROT, 0);
        end
        2: begin
          write_reg(CFG_RADIUS, 63);
          write_reg(CFG_TRANS, $urandom_range(0, 100000));
          write_reg(CFG_ROT, $urandom_range(0, 1000000));
        end
        3: begin
          write_reg(CFG_RADIUS, $urandom_range(0, 63));
          write_reg(CFG_TRANS, 32'(TRANS_RST));
          write_reg(CFG_ROT, 32'(ROT_RST));
        end
        default: begin
          write_reg(CFG_RADIUS, $urandom_range(0, 32));
          write_reg(CFG_TRANS, $urandom());
          write_reg(CFG_ROT, $urandom_range(0, 600000));
        end
      endcase
      repeat (290) random_request(40);
    end

    drain();
    write_reg(CFG_RADIUS, 2);
    repeat (40) random_request(50);

    drain();
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #60ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

>>> filelist.f
rtl/gts_pkg.sv
rtl/gts_ram.sv
rtl/gts_ctrl.sv
rtl/gts_datapath.sv
rtl/gaussian_trajectory_smoother.sv
rtl/gts_checker.sv
tb/smoother_checker.sv
tb/gaussian_trajectory_smoother_test.sv
